FILE: rtl/core/bers_pkg.sv
// Shared types, widths and arithmetic helpers for the ball edge reflection step.
// Used by bers_ctrl, bers_dp and ball_edge_reflection_step; depends on nothing.
`default_nettype none

package bers_pkg;

   // Field widths.
   localparam int COORD_W    = 20;
   localparam int EXT_W      = COORD_W + 1;
   localparam int TIME_W     = 16;
   localparam int RAD_W      = 16;
   localparam int GRAV_W     = 20;
   localparam int FRIC_W     = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Datapath widths.
   localparam int SCALE_W    = 17;
   localparam int MA_W       = 24;
   localparam int MB_W       = 21;
   localparam int PROD_W     = MA_W + MB_W;
   localparam int RND_W      = 48;
   localparam int RNDO_W     = RND_W - 16;
   localparam int SUM_W      = 33;
   localparam int ACC_W      = 46;
   localparam int SQ_W       = 60;
   localparam int LEN_W      = 30;
   localparam int DIV_W      = 48;
   localparam int QUO_W      = 18;
   localparam int NRM_W      = 18;
   localparam int SQ_SHIFT   = 18;
   localparam int UNIT_SHIFT = 26;
   localparam int SQ_STEPS   = 30;
   localparam int DIV_STEPS  = 18;
   localparam int CNT_W      = 5;

   localparam logic [RAD_W-1:0]  RADIUS_RESET   = RAD_W'(2560);
   localparam logic [SCALE_W-1:0] SCALE_ONE     = SCALE_W'(65536);

   typedef enum logic [1:0] {
      MODE_PLACE   = 2'd0,
      MODE_ADVANCE = 2'd1,
      MODE_EDGE    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_RADIUS   = 2'd0,
      CSR_GRAVITY  = 2'd1,
      CSR_FRICTION = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_WB, ST_SQ_INIT, ST_SQ_STEP, ST_DV_INIT, ST_DV_STEP, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      UOP_GRAV, UOP_FRIC, UOP_SCALE_X, UOP_SCALE_Y, UOP_MOVE_X, UOP_MOVE_Y,
      UOP_SQ_X, UOP_SQ_Y, UOP_DIST_X, UOP_DIST_Y, UOP_VN_X, UOP_VN_Y, UOP_PREP,
      UOP_REFL_X, UOP_REFL_Y, UOP_PUSH_X, UOP_PUSH_Y
   } uop_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_PLACE, OP_CAPTURE, OP_MUL, OP_WB,
      OP_SQ_INIT, OP_SQ_STEP, OP_DV_INIT, OP_DV_STEP, OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      uop_type   uop;
      logic      div_y;
      logic      last;
   } dp_cmd_type;

   typedef struct packed {
      logic edge_zero;
      logic hit_now;
   } dp_status_type;

   // Shift right by 16 with rounding to nearest, ties away from zero.
   function automatic logic signed [RNDO_W-1:0] rnd16(input logic signed [RND_W-1:0] v);
      logic signed [RND_W-1:0] t;
      t = v + RND_W'(32768) - RND_W'({1'b0, v[RND_W-1]});
      return t[RND_W-1:16];
   endfunction

   // Saturate to the signed coordinate range.
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         return hi[COORD_W-1:0];
      end else if (v < lo) begin
         return lo[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bers_ctrl.sv
// Controller state machine of the ball edge reflection step.
// Depends on bers_pkg; drives bers_dp through command and status structs.
`default_nettype none

module bers_ctrl (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [bers_pkg::MODE_W-1:0]      req_mode,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output bers_pkg::dp_cmd_type             cmd,
   input  bers_pkg::dp_status_type          st
);

   bers_pkg::state_type            state_ff, state_in;
   bers_pkg::uop_type              uop_ff, uop_in;
   logic [bers_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                           div_y_ff, div_y_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bers_pkg::ST_IDLE;
         uop_ff       <= bers_pkg::UOP_GRAV;
         cnt_ff       <= '0;
         div_y_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         uop_ff       <= uop_in;
         cnt_ff       <= cnt_in;
         div_y_ff     <= div_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == bers_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      uop_in       = uop_ff;
      cnt_in       = cnt_ff;
      div_y_in     = div_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = bers_pkg::OP_NONE;
      cmd.uop      = uop_ff;
      cmd.div_y    = div_y_ff;
      cmd.last     = 1'b0;
      case (state_ff)
         bers_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  bers_pkg::MODE_PLACE: begin
                     cmd.op   = bers_pkg::OP_PLACE;
                     state_in = bers_pkg::ST_DONE;
                  end
                  bers_pkg::MODE_ADVANCE: begin
                     cmd.op   = bers_pkg::OP_CAPTURE;
                     uop_in   = bers_pkg::UOP_GRAV;
                     state_in = bers_pkg::ST_MUL;
                  end
                  bers_pkg::MODE_EDGE: begin
                     cmd.op   = bers_pkg::OP_CAPTURE;
                     uop_in   = bers_pkg::UOP_SQ_X;
                     state_in = bers_pkg::ST_MUL;
                  end
                  default: begin
                     cmd.op   = bers_pkg::OP_CAPTURE;
                     state_in = bers_pkg::ST_DONE;
                  end
               endcase
            end
         end
         bers_pkg::ST_MUL: begin
            cmd.op   = bers_pkg::OP_MUL;
            state_in = bers_pkg::ST_WB;
         end
         bers_pkg::ST_WB: begin
            cmd.op   = bers_pkg::OP_WB;
            state_in = bers_pkg::ST_MUL;
            case (uop_ff)
               bers_pkg::UOP_GRAV:    uop_in = bers_pkg::UOP_FRIC;
               bers_pkg::UOP_FRIC:    uop_in = bers_pkg::UOP_SCALE_X;
               bers_pkg::UOP_SCALE_X: uop_in = bers_pkg::UOP_SCALE_Y;
               bers_pkg::UOP_SCALE_Y: uop_in = bers_pkg::UOP_MOVE_X;
               bers_pkg::UOP_MOVE_X:  uop_in = bers_pkg::UOP_MOVE_Y;
               bers_pkg::UOP_SQ_X:    uop_in = bers_pkg::UOP_SQ_Y;
               bers_pkg::UOP_SQ_Y: begin
                  state_in = st.edge_zero ? bers_pkg::ST_DONE : bers_pkg::ST_SQ_INIT;
               end
               bers_pkg::UOP_DIST_X:  uop_in = bers_pkg::UOP_DIST_Y;
               bers_pkg::UOP_DIST_Y:  uop_in = bers_pkg::UOP_VN_X;
               bers_pkg::UOP_VN_X:    uop_in = bers_pkg::UOP_VN_Y;
               bers_pkg::UOP_VN_Y:    uop_in = bers_pkg::UOP_PREP;
               bers_pkg::UOP_PREP: begin
                  if (st.hit_now) begin
                     uop_in = bers_pkg::UOP_REFL_X;
                  end else begin
                     state_in = bers_pkg::ST_DONE;
                  end
               end
               bers_pkg::UOP_REFL_X:  uop_in = bers_pkg::UOP_REFL_Y;
               bers_pkg::UOP_REFL_Y:  uop_in = bers_pkg::UOP_PUSH_X;
               bers_pkg::UOP_PUSH_X:  uop_in = bers_pkg::UOP_PUSH_Y;
               default:               state_in = bers_pkg::ST_DONE;
            endcase
         end
         bers_pkg::ST_SQ_INIT: begin
            cmd.op   = bers_pkg::OP_SQ_INIT;
            cnt_in   = '0;
            state_in = bers_pkg::ST_SQ_STEP;
         end
         bers_pkg::ST_SQ_STEP: begin
            cmd.op = bers_pkg::OP_SQ_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == bers_pkg::CNT_W'(bers_pkg::SQ_STEPS - 1)) begin
               div_y_in = 1'b0;
               state_in = bers_pkg::ST_DV_INIT;
            end
         end
         bers_pkg::ST_DV_INIT: begin
            cmd.op   = bers_pkg::OP_DV_INIT;
            cnt_in   = '0;
            state_in = bers_pkg::ST_DV_STEP;
         end
         bers_pkg::ST_DV_STEP: begin
            cmd.op   = bers_pkg::OP_DV_STEP;
            cmd.last = (cnt_ff == bers_pkg::CNT_W'(bers_pkg::DIV_STEPS - 1));
            cnt_in   = cnt_ff + 1'b1;
            if (cmd.last) begin
               if (!div_y_ff) begin
                  div_y_in = 1'b1;
                  state_in = bers_pkg::ST_DV_INIT;
               end else begin
                  uop_in   = bers_pkg::UOP_DIST_X;
                  state_in = bers_pkg::ST_MUL;
               end
            end
         end
         bers_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.op       = bers_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = bers_pkg::ST_IDLE;
            end
         end
         default: state_in = bers_pkg::ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != bers_pkg::ST_IDLE))
      else $error("accepted transaction did not start work");
   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bers_pkg::ST_DONE && out_free) |=>
      (rsp_valid_ff && state_ff == bers_pkg::ST_IDLE))
      else $error("finished result was not presented");
   a_sqrt_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bers_pkg::ST_SQ_STEP) |-> (cnt_ff < bers_pkg::CNT_W'(bers_pkg::SQ_STEPS)))
      else $error("square root step count overran");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bers_pkg::ST_DV_STEP) |-> (cnt_ff < bers_pkg::CNT_W'(bers_pkg::DIV_STEPS)))
      else $error("divide step count overran");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/bers_dp.sv
// Datapath of the ball edge reflection step: ball state, settings, shared multiplier,
// square root and divide iterations. Depends on bers_pkg; commanded by bers_ctrl.
`default_nettype none

module bers_dp (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      csr_write_enable,
   input  wire        [bers_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire        [bers_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  wire signed [bers_pkg::COORD_W-1:0]       req_place_pos_x,
   input  wire signed [bers_pkg::COORD_W-1:0]       req_place_pos_y,
   input  wire signed [bers_pkg::COORD_W-1:0]       req_place_vel_x,
   input  wire signed [bers_pkg::COORD_W-1:0]       req_place_vel_y,
   input  wire        [bers_pkg::TIME_W-1:0]        req_time_step,
   input  wire signed [bers_pkg::COORD_W-1:0]       req_edge_ax,
   input  wire signed [bers_pkg::COORD_W-1:0]       req_edge_ay,
   input  wire signed [bers_pkg::COORD_W-1:0]       req_edge_bx,
   input  wire signed [bers_pkg::COORD_W-1:0]       req_edge_by,
   input  bers_pkg::dp_cmd_type                     cmd,
   output bers_pkg::dp_status_type                  st,
   output logic signed [bers_pkg::COORD_W-1:0]      rsp_ball_x,
   output logic signed [bers_pkg::COORD_W-1:0]      rsp_ball_y,
   output logic signed [bers_pkg::COORD_W-1:0]      rsp_ball_vx,
   output logic signed [bers_pkg::COORD_W-1:0]      rsp_ball_vy,
   output logic                                     rsp_collided
);

   localparam int CW = bers_pkg::COORD_W;
   localparam int EW = bers_pkg::EXT_W;

   // Settings and ball state.
   logic        [bers_pkg::RAD_W-1:0]    radius_ff, radius_in;
   logic signed [bers_pkg::GRAV_W-1:0]   gravity_ff, gravity_in;
   logic        [bers_pkg::FRIC_W-1:0]   friction_ff, friction_in;
   logic signed [CW-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [CW-1:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;

   // Working registers.
   logic        [bers_pkg::TIME_W-1:0]   dt_ff, dt_in;
   logic signed [EW-1:0]  ex_ff, ex_in, ey_ff, ey_in, rx_ff, rx_in, ry_ff, ry_in;
   logic                  edge_zero_ff, edge_zero_in, hit_ff, hit_in;
   logic        [bers_pkg::SCALE_W-1:0]  s_ff, s_in;
   logic signed [bers_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [bers_pkg::ACC_W-1:0]    acc_ff, acc_in, vn_ff, vn_in;
   logic signed [bers_pkg::MA_W-1:0]     q_ff, q_in, d_ff, d_in;
   logic        [bers_pkg::SQ_W-1:0]     sq_x_ff, sq_x_in, sq_r_ff, sq_r_in;
   logic        [bers_pkg::SQ_W-1:0]     sq_bit_ff, sq_bit_in;
   logic        [bers_pkg::DIV_W-1:0]    dv_rem_ff, dv_rem_in, dv_dsh_ff, dv_dsh_in;
   logic        [bers_pkg::QUO_W-1:0]    dv_q_ff, dv_q_in;
   logic                                 dv_neg_ff, dv_neg_in;
   logic signed [bers_pkg::NRM_W-1:0]    nx_ff, nx_in, ny_ff, ny_in;
   logic signed [CW-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic signed [CW-1:0] out_vx_ff, out_vx_in, out_vy_ff, out_vy_in;
   logic                 out_hit_ff, out_hit_in;

   // Combinational helpers.
   logic signed [bers_pkg::MA_W-1:0]     mul_a;
   logic signed [bers_pkg::MB_W-1:0]     mul_b;
   logic signed [bers_pkg::RNDO_W-1:0]   pr;
   logic signed [bers_pkg::RND_W-1:0]    rr, vn2, gap;
   logic        [bers_pkg::SQ_W-1:0]     sq_t;
   logic        [EW-1:0]                 mag;
   logic                                 dv_ge;
   logic        [bers_pkg::QUO_W-1:0]    q_next;
   logic signed [bers_pkg::NRM_W-1:0]    n_mag;
   logic        [bers_pkg::LEN_W-1:0]    len;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= bers_pkg::RADIUS_RESET;
         gravity_ff  <= '0;
         friction_ff <= '0;
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         vel_x_ff    <= '0;
         vel_y_ff    <= '0;
      end else begin
         radius_ff   <= radius_in;
         gravity_ff  <= gravity_in;
         friction_ff <= friction_in;
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         vel_x_ff    <= vel_x_in;
         vel_y_ff    <= vel_y_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      edge_zero_ff <= edge_zero_in;
      hit_ff       <= hit_in;
      s_ff         <= s_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      vn_ff        <= vn_in;
      q_ff         <= q_in;
      d_ff         <= d_in;
      sq_x_ff      <= sq_x_in;
      sq_r_ff      <= sq_r_in;
      sq_bit_ff    <= sq_bit_in;
      dv_rem_ff    <= dv_rem_in;
      dv_dsh_ff    <= dv_dsh_in;
      dv_q_ff      <= dv_q_in;
      dv_neg_ff    <= dv_neg_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_vx_ff    <= out_vx_in;
      out_vy_ff    <= out_vy_in;
      out_hit_ff   <= out_hit_in;
   end

   // Multiplier operands follow the micro-operation.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.uop)
         bers_pkg::UOP_GRAV: begin
            mul_a = bers_pkg::MA_W'(gravity_ff);
            mul_b = bers_pkg::MB_W'($signed({1'b0, dt_ff}));
         end
         bers_pkg::UOP_FRIC: begin
            mul_a = bers_pkg::MA_W'($signed({1'b0, friction_ff}));
            mul_b = bers_pkg::MB_W'($signed({1'b0, dt_ff}));
         end
         bers_pkg::UOP_SCALE_X: begin
            mul_a = bers_pkg::MA_W'(vel_x_ff);
            mul_b = bers_pkg::MB_W'($signed({1'b0, s_ff}));
         end
         bers_pkg::UOP_SCALE_Y: begin
            mul_a = bers_pkg::MA_W'(vel_y_ff);
            mul_b = bers_pkg::MB_W'($signed({1'b0, s_ff}));
         end
         bers_pkg::UOP_MOVE_X: begin
            mul_a = bers_pkg::MA_W'(vel_x_ff);
            mul_b = bers_pkg::MB_W'($signed({1'b0, dt_ff}));
         end
         bers_pkg::UOP_MOVE_Y: begin
            mul_a = bers_pkg::MA_W'(vel_y_ff);
            mul_b = bers_pkg::MB_W'($signed({1'b0, dt_ff}));
         end
         bers_pkg::UOP_SQ_X: begin
            mul_a = bers_pkg::MA_W'(ex_ff);
            mul_b = bers_pkg::MB_W'(ex_ff);
         end
         bers_pkg::UOP_SQ_Y: begin
            mul_a = bers_pkg::MA_W'(ey_ff);
            mul_b = bers_pkg::MB_W'(ey_ff);
         end
         bers_pkg::UOP_DIST_X: begin
            mul_a = bers_pkg::MA_W'(rx_ff);
            mul_b = bers_pkg::MB_W'(nx_ff);
         end
         bers_pkg::UOP_DIST_Y: begin
            mul_a = bers_pkg::MA_W'(ry_ff);
            mul_b = bers_pkg::MB_W'(ny_ff);
         end
         bers_pkg::UOP_VN_X: begin
            mul_a = bers_pkg::MA_W'(vel_x_ff);
            mul_b = bers_pkg::MB_W'(nx_ff);
         end
         bers_pkg::UOP_VN_Y: begin
            mul_a = bers_pkg::MA_W'(vel_y_ff);
            mul_b = bers_pkg::MB_W'(ny_ff);
         end
         bers_pkg::UOP_REFL_X: begin
            mul_a = q_ff;
            mul_b = bers_pkg::MB_W'(nx_ff);
         end
         bers_pkg::UOP_REFL_Y: begin
            mul_a = q_ff;
            mul_b = bers_pkg::MB_W'(ny_ff);
         end
         bers_pkg::UOP_PUSH_X: begin
            mul_a = d_ff;
            mul_b = bers_pkg::MB_W'(nx_ff);
         end
         bers_pkg::UOP_PUSH_Y: begin
            mul_a = d_ff;
            mul_b = bers_pkg::MB_W'(ny_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign pr     = bers_pkg::rnd16(bers_pkg::RND_W'(prod_ff));
   assign rr     = bers_pkg::RND_W'($signed({1'b0, radius_ff, 16'b0}));
   assign vn2    = bers_pkg::RND_W'(vn_ff) <<< 1;
   assign gap    = rr - bers_pkg::RND_W'(acc_ff);
   assign sq_t   = sq_r_ff + sq_bit_ff;
   assign len    = sq_r_ff[bers_pkg::LEN_W-1:0];
   assign dv_ge  = (dv_rem_ff >= dv_dsh_ff);
   assign q_next = {dv_q_ff[bers_pkg::QUO_W-2:0], dv_ge};
   assign n_mag  = bers_pkg::NRM_W'($signed({1'b0, q_next}));

   // The x normal component divides -ey, the y component divides ex.
   always_comb begin
      if (cmd.div_y) begin
         mag = ex_ff[EW-1] ? EW'(-ex_ff) : EW'(ex_ff);
      end else begin
         mag = ey_ff[EW-1] ? EW'(-ey_ff) : EW'(ey_ff);
      end
   end

   assign st = '{edge_zero: edge_zero_ff,
                 hit_now:   (bers_pkg::RND_W'(acc_ff) < rr) && vn_ff[bers_pkg::ACC_W-1]};

   always_comb begin
      radius_in    = radius_ff;
      gravity_in   = gravity_ff;
      friction_in  = friction_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      dt_in        = dt_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      edge_zero_in = edge_zero_ff;
      hit_in       = hit_ff;
      s_in         = s_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      vn_in        = vn_ff;
      q_in         = q_ff;
      d_in         = d_ff;
      sq_x_in      = sq_x_ff;
      sq_r_in      = sq_r_ff;
      sq_bit_in    = sq_bit_ff;
      dv_rem_in    = dv_rem_ff;
      dv_dsh_in    = dv_dsh_ff;
      dv_q_in      = dv_q_ff;
      dv_neg_in    = dv_neg_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_vx_in    = out_vx_ff;
      out_vy_in    = out_vy_ff;
      out_hit_in   = out_hit_ff;

      if (csr_write_enable) begin
         case (csr_index)
            bers_pkg::CSR_RADIUS:   radius_in   = csr_write_data[bers_pkg::RAD_W-1:0];
            bers_pkg::CSR_GRAVITY:  gravity_in  = $signed(csr_write_data[bers_pkg::GRAV_W-1:0]);
            bers_pkg::CSR_FRICTION: friction_in = csr_write_data[bers_pkg::FRIC_W-1:0];
            default:                radius_in   = radius_ff;
         endcase
      end

      case (cmd.op)
         bers_pkg::OP_PLACE: begin
            pos_x_in = req_place_pos_x;
            pos_y_in = req_place_pos_y;
            vel_x_in = req_place_vel_x;
            vel_y_in = req_place_vel_y;
            hit_in   = 1'b0;
         end
         bers_pkg::OP_CAPTURE: begin
            dt_in        = req_time_step;
            ex_in        = EW'(req_edge_bx) - EW'(req_edge_ax);
            ey_in        = EW'(req_edge_by) - EW'(req_edge_ay);
            rx_in        = EW'(pos_x_ff) - EW'(req_edge_ax);
            ry_in        = EW'(pos_y_ff) - EW'(req_edge_ay);
            edge_zero_in = (req_edge_ax == req_edge_bx) && (req_edge_ay == req_edge_by);
            hit_in       = 1'b0;
         end
         bers_pkg::OP_MUL: begin
            prod_in = mul_a * mul_b;
         end
         bers_pkg::OP_WB: begin
            case (cmd.uop)
               bers_pkg::UOP_GRAV:
                  vel_y_in = bers_pkg::sat_coord(bers_pkg::SUM_W'(vel_y_ff) + bers_pkg::SUM_W'(pr));
               bers_pkg::UOP_FRIC:
                  s_in = bers_pkg::SCALE_ONE - pr[bers_pkg::SCALE_W-1:0];
               bers_pkg::UOP_SCALE_X:
                  vel_x_in = bers_pkg::sat_coord(bers_pkg::SUM_W'(pr));
               bers_pkg::UOP_SCALE_Y:
                  vel_y_in = bers_pkg::sat_coord(bers_pkg::SUM_W'(pr));
               bers_pkg::UOP_MOVE_X:
                  pos_x_in = bers_pkg::sat_coord(bers_pkg::SUM_W'(pos_x_ff) + bers_pkg::SUM_W'(pr));
               bers_pkg::UOP_MOVE_Y:
                  pos_y_in = bers_pkg::sat_coord(bers_pkg::SUM_W'(pos_y_ff) + bers_pkg::SUM_W'(pr));
               bers_pkg::UOP_SQ_X, bers_pkg::UOP_DIST_X:
                  acc_in = bers_pkg::ACC_W'(prod_ff);
               bers_pkg::UOP_SQ_Y, bers_pkg::UOP_DIST_Y:
                  acc_in = acc_ff + bers_pkg::ACC_W'(prod_ff);
               bers_pkg::UOP_VN_X:
                  vn_in = bers_pkg::ACC_W'(prod_ff);
               bers_pkg::UOP_VN_Y:
                  vn_in = vn_ff + bers_pkg::ACC_W'(prod_ff);
               bers_pkg::UOP_PREP: begin
                  q_in   = bers_pkg::MA_W'(bers_pkg::rnd16(vn2));
                  d_in   = bers_pkg::MA_W'(bers_pkg::rnd16(gap));
                  hit_in = st.hit_now;
               end
               bers_pkg::UOP_REFL_X:
                  vel_x_in = bers_pkg::sat_coord(bers_pkg::SUM_W'(vel_x_ff) - bers_pkg::SUM_W'(pr));
               bers_pkg::UOP_REFL_Y:
                  vel_y_in = bers_pkg::sat_coord(bers_pkg::SUM_W'(vel_y_ff) - bers_pkg::SUM_W'(pr));
               bers_pkg::UOP_PUSH_X:
                  pos_x_in = bers_pkg::sat_coord(bers_pkg::SUM_W'(pos_x_ff) + bers_pkg::SUM_W'(pr));
               bers_pkg::UOP_PUSH_Y:
                  pos_y_in = bers_pkg::sat_coord(bers_pkg::SUM_W'(pos_y_ff) + bers_pkg::SUM_W'(pr));
               default: acc_in = acc_ff;
            endcase
         end
         bers_pkg::OP_SQ_INIT: begin
            // Length is sqrt(S * 2^18); the acc register holds S here.
            sq_x_in   = bers_pkg::SQ_W'(acc_ff) << bers_pkg::SQ_SHIFT;
            sq_r_in   = '0;
            sq_bit_in = bers_pkg::SQ_W'(1) << (2 * (bers_pkg::SQ_STEPS - 1));
         end
         bers_pkg::OP_SQ_STEP: begin
            if (sq_x_ff >= sq_t) begin
               sq_x_in = sq_x_ff - sq_t;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
         end
         bers_pkg::OP_DV_INIT: begin
            // Rounded quotient: (m * 2^26 + len) / (2 * len).
            dv_rem_in = (bers_pkg::DIV_W'(mag) << bers_pkg::UNIT_SHIFT) + bers_pkg::DIV_W'(len);
            dv_dsh_in = bers_pkg::DIV_W'(len) << bers_pkg::QUO_W;
            dv_q_in   = '0;
            dv_neg_in = cmd.div_y ? ex_ff[EW-1] : (!ey_ff[EW-1] && (ey_ff != '0));
         end
         bers_pkg::OP_DV_STEP: begin
            if (dv_ge) begin
               dv_rem_in = dv_rem_ff - dv_dsh_ff;
            end
            dv_dsh_in = dv_dsh_ff >> 1;
            dv_q_in   = q_next;
            if (cmd.last) begin
               if (cmd.div_y) begin
                  ny_in = dv_neg_ff ? -n_mag : n_mag;
               end else begin
                  nx_in = dv_neg_ff ? -n_mag : n_mag;
               end
            end
         end
         bers_pkg::OP_OUT: begin
            out_x_in   = pos_x_ff;
            out_y_in   = pos_y_ff;
            out_vx_in  = vel_x_ff;
            out_vy_in  = vel_y_ff;
            out_hit_in = hit_ff;
         end
         default: prod_in = prod_ff;
      endcase
   end

   assign rsp_ball_x   = out_x_ff;
   assign rsp_ball_y   = out_y_ff;
   assign rsp_ball_vx  = out_vx_ff;
   assign rsp_ball_vy  = out_vy_ff;
   assign rsp_collided = out_hit_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ball_edge_reflection_step.sv
// Top level of the ball edge reflection step.
// Depends on bers_pkg and instantiates bers_ctrl and bers_dp.
//
// Usage:
//   The block holds one ball (position and velocity, signed Q12.8). Each request
//   transaction on the req_ channel places the ball, advances it by a time step,
//   or tests it against one counterclockwise edge. Every request produces
//   exactly one response transaction on the rsp_ channel carrying the ball state
//   after the request and a collided flag.
//   Place and the unused mode go straight to the result. The edge test is
//   set by the 30-step square root and the two 18-step divides that build
//   the unit normal, plus each use of the single shared 24x21 multiplier;
//   a zero-length edge stops after squaring, an edge without contact before
//   the reflection. Requests are worked on one at a time; req_ready is
//   high whenever no request is in progress.
//   The result sits in an output register, so a new request is taken while an
//   earlier response still waits; a stalled receiver only holds the block once
//   the next result is finished.
//   Reset (synchronous, active high) clears the ball state to zero, sets the
//   radius to 10 pixels, gravity and friction to zero, and drops rsp_valid.
//   Settings must be written via csr_ while the block is idle (not enforced).
`default_nettype none

module ball_edge_reflection_step (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     csr_write_enable,
   input  wire        [bers_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire        [bers_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire        [bers_pkg::MODE_W-1:0]       req_mode,
   input  wire signed [bers_pkg::COORD_W-1:0]      req_place_pos_x,
   input  wire signed [bers_pkg::COORD_W-1:0]      req_place_pos_y,
   input  wire signed [bers_pkg::COORD_W-1:0]      req_place_vel_x,
   input  wire signed [bers_pkg::COORD_W-1:0]      req_place_vel_y,
   input  wire        [bers_pkg::TIME_W-1:0]       req_time_step,
   input  wire signed [bers_pkg::COORD_W-1:0]      req_edge_ax,
   input  wire signed [bers_pkg::COORD_W-1:0]      req_edge_ay,
   input  wire signed [bers_pkg::COORD_W-1:0]      req_edge_bx,
   input  wire signed [bers_pkg::COORD_W-1:0]      req_edge_by,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic signed [bers_pkg::COORD_W-1:0]     rsp_ball_x,
   output logic signed [bers_pkg::COORD_W-1:0]     rsp_ball_y,
   output logic signed [bers_pkg::COORD_W-1:0]     rsp_ball_vx,
   output logic signed [bers_pkg::COORD_W-1:0]     rsp_ball_vy,
   output logic                                    rsp_collided
);

   // Command and status between the sequencer and the arithmetic.
   bers_pkg::dp_cmd_type    cmd;
   bers_pkg::dp_status_type st;

   // The controller owns the handshakes and steps through the micro-operations.
   bers_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .st        (st)
   );

   // The datapath holds the ball, the settings and the result register.
   bers_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_place_pos_x  (req_place_pos_x),
      .req_place_pos_y  (req_place_pos_y),
      .req_place_vel_x  (req_place_vel_x),
      .req_place_vel_y  (req_place_vel_y),
      .req_time_step    (req_time_step),
      .req_edge_ax      (req_edge_ax),
      .req_edge_ay      (req_edge_ay),
      .req_edge_bx      (req_edge_bx),
      .req_edge_by      (req_edge_by),
      .cmd              (cmd),
      .st               (st),
      .rsp_ball_x       (rsp_ball_x),
      .rsp_ball_y       (rsp_ball_y),
      .rsp_ball_vx      (rsp_ball_vx),
      .rsp_ball_vy      (rsp_ball_vy),
      .rsp_collided     (rsp_collided)
   );

endmodule

`default_nettype wire

FILE: bench/tb_ball_edge_reflection_step.sv
// Self-checking regression for the ball edge reflection step.
// Depends on bers_pkg and the ball_edge_reflection_step top level.
`default_nettype none

module tb_ball_edge_reflection_step;

   localparam int CW = bers_pkg::COORD_W;
   localparam int COORD_MAX = 524287;
   localparam int COORD_MIN = -524288;
   localparam longint NORM_LIMIT = 2097152;
   localparam longint RUN_LIMIT = 2000000;
   // Mode code that the block treats as a no-op.
   localparam logic [bers_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [bers_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bers_pkg::CSR_DATA_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [bers_pkg::MODE_W-1:0] req_mode = '0;
   logic signed [CW-1:0] req_place_pos_x = '0, req_place_pos_y = '0;
   logic signed [CW-1:0] req_place_vel_x = '0, req_place_vel_y = '0;
   logic [bers_pkg::TIME_W-1:0] req_time_step = '0;
   logic signed [CW-1:0] req_edge_ax = '0, req_edge_ay = '0;
   logic signed [CW-1:0] req_edge_bx = '0, req_edge_by = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [CW-1:0] rsp_ball_x, rsp_ball_y, rsp_ball_vx, rsp_ball_vy;
   logic rsp_collided;

   ball_edge_reflection_step dut (.*);

   always #1 clock = ~clock;

   // One expected ball state per request transaction.
   typedef struct packed {
      logic signed [CW-1:0] x, y, vx, vy;
      logic hit;
   } ball_state_type;

   ball_state_type expected_states[$];

   // Shadow copy of the ball and the settings.
   longint ball_px, ball_py, ball_vx, ball_vy;
   longint radius_q, gravity_q, friction_q;

   int mismatch_count = 0;
   longint cycle_count = 0;
   int idle_pct = 17;      // Chance, in percent, that either side idles.
   int hold_cycles = 0;    // Receiver hold-off requested by a test.

   function automatic longint clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // Shift right by n with rounding half away from zero.
   function automatic longint round_shift(longint v, int n);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (n - 1))) >>> n;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint unit_part(longint c, longint len);
      longint unsigned m, q, l;
      m = (c < 0) ? -c : c;
      l = len;
      q = ((m << 26) + l) / (l << 1);
      return (c < 0) ? -longint'(q) : longint'(q);
   endfunction

   // Advance: gravity, then friction, then motion.
   task automatic advance_ball(longint dt);
      longint s;
      s = 65536 - round_shift(friction_q * dt, 16);
      ball_vy = clamp_coord(ball_vy + round_shift(gravity_q * dt, 16));
      ball_vx = clamp_coord(round_shift(ball_vx * s, 16));
      ball_vy = clamp_coord(round_shift(ball_vy * s, 16));
      ball_px = clamp_coord(ball_px + round_shift(ball_vx * dt, 16));
      ball_py = clamp_coord(ball_py + round_shift(ball_vy * dt, 16));
   endtask

   // Edge test: returns 1 when the ball is reflected off the edge.
   function automatic bit bounce_off_edge(longint ax, longint ay, longint bx, longint by);
      longint ex, ey, len, nx, ny, sep, vn, rr, q, d;
      ex = bx - ax;
      ey = by - ay;
      if (ex == 0 && ey == 0) return 1'b0;
      // Long edges are halved, truncating toward zero, to bound the square.
      while (ex > NORM_LIMIT || ex < -NORM_LIMIT || ey > NORM_LIMIT || ey < -NORM_LIMIT) begin
         ex = ex / 2;
         ey = ey / 2;
      end
      len = int_sqrt(longint'(ex * ex + ey * ey) << 18);
      nx = unit_part(-ey, len);
      ny = unit_part(ex, len);
      sep = (ball_px - ax) * nx + (ball_py - ay) * ny;
      vn = ball_vx * nx + ball_vy * ny;
      rr = radius_q <<< 16;
      if (sep < rr && vn < 0) begin
         q = round_shift(2 * vn, 16);
         d = round_shift(rr - sep, 16);
         ball_vx = clamp_coord(ball_vx - round_shift(q * nx, 16));
         ball_vy = clamp_coord(ball_vy - round_shift(q * ny, 16));
         ball_px = clamp_coord(ball_px + round_shift(d * nx, 16));
         ball_py = clamp_coord(ball_py + round_shift(d * ny, 16));
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Sends one request transaction and records the ball state it should leave.
   // Valid stays high after acceptance; the next call, or the drain, replaces it
   // in the same time step, while the block is still busy.
   task automatic send_request(logic [bers_pkg::MODE_W-1:0] mode,
                               logic signed [CW-1:0] px,
                               logic signed [CW-1:0] py,
                               logic signed [CW-1:0] vx,
                               logic signed [CW-1:0] vy,
                               logic [bers_pkg::TIME_W-1:0] dt,
                               logic signed [CW-1:0] ax,
                               logic signed [CW-1:0] ay,
                               logic signed [CW-1:0] bx,
                               logic signed [CW-1:0] by);
      ball_state_type st;
      bit hit;
      hit = 1'b0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_place_pos_x <= px;
      req_place_pos_y <= py;
      req_place_vel_x <= vx;
      req_place_vel_y <= vy;
      req_time_step <= dt;
      req_edge_ax <= ax;
      req_edge_ay <= ay;
      req_edge_bx <= bx;
      req_edge_by <= by;
      do @(posedge clock); while (!req_ready);
      case (mode)
         bers_pkg::MODE_PLACE: begin
            ball_px = longint'(px);
            ball_py = longint'(py);
            ball_vx = longint'(vx);
            ball_vy = longint'(vy);
         end
         bers_pkg::MODE_ADVANCE: advance_ball(longint'(dt));
         bers_pkg::MODE_EDGE:
            hit = bounce_off_edge(longint'(ax), longint'(ay), longint'(bx), longint'(by));
         default: ;
      endcase
      st.x = ball_px[CW-1:0];
      st.y = ball_py[CW-1:0];
      st.vx = ball_vx[CW-1:0];
      st.vy = ball_vy[CW-1:0];
      st.hit = hit;
      expected_states.insert(expected_states.size(), st);
   endtask

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(5))
         0: return CW'(COORD_MAX);
         1: return CW'(COORD_MIN);
         2: return CW'(int'($urandom_range(8191)) - 4096);
         default: return CW'($urandom);
      endcase
   endfunction

   task automatic send_place(longint px, longint py, longint vx, longint vy);
      send_request(bers_pkg::MODE_PLACE, CW'(px), CW'(py), CW'(vx), CW'(vy),
                   bers_pkg::TIME_W'($urandom), CW'($urandom), CW'($urandom),
                   CW'($urandom), CW'($urandom));
   endtask

   task automatic send_advance(logic [bers_pkg::TIME_W-1:0] dt);
      send_request(bers_pkg::MODE_ADVANCE, CW'($urandom), CW'($urandom), CW'($urandom),
                   CW'($urandom), dt, CW'($urandom), CW'($urandom), CW'($urandom),
                   CW'($urandom));
   endtask

   task automatic send_edge(longint ax, longint ay, longint bx, longint by);
      send_request(bers_pkg::MODE_EDGE, CW'($urandom), CW'($urandom), CW'($urandom),
                   CW'($urandom), bers_pkg::TIME_W'($urandom), CW'(ax), CW'(ay),
                   CW'(bx), CW'(by));
   endtask

   // Waits until every response has arrived, plus the longest edge latency.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_states.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_setting(bers_pkg::csr_index_type idx,
                                logic [bers_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         bers_pkg::CSR_RADIUS: radius_q = longint'(value[bers_pkg::RAD_W-1:0]);
         bers_pkg::CSR_GRAVITY:
            gravity_q = longint'(signed'(value[bers_pkg::GRAV_W-1:0]));
         bers_pkg::CSR_FRICTION: friction_q = longint'(value[bers_pkg::FRIC_W-1:0]);
         default: ;
      endcase
   endtask

   // Directed cases: field extremes, every mode, zero-length edge, saturation.
   task automatic test_directed();
      send_place(0, 0, 0, 0);
      send_place(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
      send_advance(16'hFFFF);
      send_advance(16'd0);
      send_request(MODE_UNUSED, 20'sd1, 20'sd2, 20'sd3, 20'sd4, 16'd5, 20'sd6, 20'sd7,
                   20'sd8, 20'sd9);
      // Ball just above a floor edge, falling onto it.
      send_place(0, 512, 100, -2000);
      send_edge(-10000, 0, 10000, 0);
      // Ball moving away from the edge is left alone.
      send_place(0, 512, 100, 2000);
      send_edge(-10000, 0, 10000, 0);
      send_edge(300, 300, 300, 300);
      send_place(0, 0, 0, 0);
      send_edge(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_place(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_edge(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      send_place(100, 100, -300000, 250000);
      send_edge(0, 5000, 0, -5000);
      send_edge(5000, 0, -5000, 0);
      send_advance(16'h8000);
      drain_responses();
   endtask

   // Mostly short bounce sequences: place, a few advances and nearby edges.
   task automatic test_random(int count);
      int n;
      longint cx, cy;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) == 0) begin
            send_request(bers_pkg::MODE_W'($urandom), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), bers_pkg::TIME_W'($urandom),
                         rand_coord(), rand_coord(), rand_coord(), rand_coord());
            n++;
         end else begin
            cx = longint'($urandom_range(40000)) - 20000;
            cy = longint'($urandom_range(40000)) - 20000;
            send_place(cx, cy, longint'($urandom_range(20000)) - 10000,
                       longint'($urandom_range(20000)) - 10000);
            n++;
            repeat ($urandom_range(4, 1)) begin
               if ($urandom_range(2) == 0) begin
                  send_advance(bers_pkg::TIME_W'($urandom_range(3000)));
               end else begin
                  send_edge(cx - longint'($urandom_range(6000)),
                            cy - longint'($urandom_range(4000)),
                            cx + longint'($urandom_range(6000)),
                            cy - longint'($urandom_range(4000)));
               end
               n++;
            end
         end
      end
   endtask

   task automatic test_settings();
      write_setting(bers_pkg::CSR_RADIUS, 20'h0FFFF);
      write_setting(bers_pkg::CSR_GRAVITY, 20'h7FFFF);
      write_setting(bers_pkg::CSR_FRICTION, 20'h0FFFF);
      test_random(150);
      drain_responses();
      write_setting(bers_pkg::CSR_RADIUS, 20'd0);
      write_setting(bers_pkg::CSR_GRAVITY, 20'h80000);
      write_setting(bers_pkg::CSR_FRICTION, 20'd0);
      test_random(150);
      drain_responses();
      write_setting(bers_pkg::CSR_RADIUS, 20'd1280);
      write_setting(bers_pkg::CSR_GRAVITY, 20'hFD800);
      write_setting(bers_pkg::CSR_FRICTION, 20'd3000);
      test_random(400);
      drain_responses();
   endtask

   // Receiver holds off while requests keep coming, so the block stalls its input.
   task automatic test_backpressure();
      hold_cycles = 600;
      test_random(20);
      drain_responses();
   endtask

   // No idling on either side for a stretch.
   task automatic test_full_rate();
      idle_pct = 0;
      test_random(300);
      drain_responses();
      idle_pct = 17;
   endtask

   // Sender pauses until everything is back, then resumes.
   task automatic test_sender_pause();
      test_random(60);
      drain_responses();
      test_random(300);
      drain_responses();
   endtask

   // Response side: random stalls plus the long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Compares each response transaction with the oldest expected state.
   always @(posedge clock) begin
      ball_state_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_states.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response at cycle %0d", cycle_count);
         end else begin
            want = expected_states.pop_front();
            if (want.x !== rsp_ball_x || want.y !== rsp_ball_y || want.vx !== rsp_ball_vx ||
                want.vy !== rsp_ball_vy || want.hit !== rsp_collided) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected x %0d y %0d vx %0d vy %0d hit %0d",
                           want.x, want.y, want.vx, want.vy, want.hit);
                  $display("          actual   x %0d y %0d vx %0d vy %0d hit %0d",
                           rsp_ball_x, rsp_ball_y, rsp_ball_vx, rsp_ball_vy, rsp_collided);
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("ball_edge_reflection_step regression: fail");
         $finish;
      end
   end

   initial begin
      ball_px = 0;
      ball_py = 0;
      ball_vx = 0;
      ball_vy = 0;
      radius_q = longint'(bers_pkg::RADIUS_RESET);
      gravity_q = 0;
      friction_q = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_settings();
      test_backpressure();
      test_full_rate();
      test_sender_pause();
      if (mismatch_count == 0 && expected_states.size() == 0) begin
         $display("ball_edge_reflection_step regression: pass");
      end else begin
         $display("ball_edge_reflection_step regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
